// ===== rtl/core/cart_pkg.sv =====
// Shared types and constants for the cumulative-ack retransmit tracker.
`timescale 1ns / 1ps
`default_nettype none

package cart_pkg;

    localparam int SEQ_W         = 48;
    localparam int LEN_W         = 16;
    localparam int HDR_W         = 8;
    localparam int OUT_CNT_W     = 7;
    localparam int DEF_DEPTH     = 64;
    localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

    typedef enum logic [1:0] {
        REQ_SEND    = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        STS_SENT      = 3'd0,
        STS_ACK_TAKEN = 3'd1,
        STS_ACK_STALE = 3'd2,
        STS_RETX      = 3'd3,
        STS_NO_RESEND = 3'd4,
        STS_FULL      = 3'd5,
        STS_TOO_SHORT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } timer_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [LEN_W-1:0] pkt_len;
        logic [SEQ_W-1:0] ack_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [SEQ_W-1:0]     seq_out;
        logic [LEN_W-1:0]     len_out;
        logic [1:0]           timer_action;
        logic [OUT_CNT_W-1:0] outstanding;
    } out_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0] start;
        logic [LEN_W-1:0] length;
    } entry_t;

    typedef enum logic [1:0] {
        CS_IDLE   = 2'd0,
        CS_DECODE = 2'd1,
        CS_WALK   = 2'd2,
        CS_EMIT   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic walk_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       stale;
        logic       walk_done;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cumulative_ack_retransmit_tracker_top.sv =====
// Top level of the cumulative-ack retransmit tracker: controller plus datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  request  | in_valid / in_ready     | in_data  (cart_pkg::in_item_t)
//  result   | out_valid / out_ready   | out_data (cart_pkg::out_item_t)
//  config   | cfg_wr_en (no wait)     | cfg_wr_data (header bytes)
//
// A send or a stale ack goes from accept through the decode and emit states into the output
// register; an ack or a timeout also sweeps the descriptor memory (one read and one write
// port) in the walk state, one entry read per cycle. Items are handled one at a time; the
// next is taken the cycle after its result is loaded.
// Reset clears base, next and the entry count; the memory needs no clearing pass.
// A finished result waits in the output register while the next item is accepted; a
// later result holds in the controller until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module cumulative_ack_retransmit_tracker_top #(
    parameter int TABLE_DEPTH = cart_pkg::DEF_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cart_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cart_pkg::out_item_t     out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data
);
    import cart_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    cart_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cart_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cart_ctrl.sv =====
// Controller state machine: sequences decode, table walk and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module cart_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cart_pkg::dp_sts_t sts,
    output cart_pkg::dp_cmd_t     cmd
);
    import cart_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                case (sts.kind)
                    REQ_SEND:    state_next = CS_EMIT;
                    REQ_ACK:     state_next = sts.stale ? CS_EMIT : CS_WALK;
                    REQ_TIMEOUT: state_next = CS_WALK;
                    default:     state_next = CS_IDLE;  // unused type: drop the item
                endcase
            end
            CS_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = CS_EMIT;
                end
            end
            CS_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            CS_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            CS_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            CS_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cart_datapath.sv =====
// Datapath: window registers, descriptor memory, walk counters and output register.
`timescale 1ns / 1ps
`default_nettype none

module cart_datapath #(
    parameter int TABLE_DEPTH = cart_pkg::DEF_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cart_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cart_pkg::out_item_t      out_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire cart_pkg::dp_cmd_t   cmd,
    output cart_pkg::dp_sts_t        sts
);
    import cart_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    logic [HDR_W-1:0] hdr_reg;
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] next_reg, next_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    in_item_t         req_reg, req_next;
    out_item_t        res_reg, res_next;
    out_item_t        out_data_reg, out_data_next;
    logic             out_valid_reg, out_valid_next;
    entry_t           rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             issue;
    logic             walk_done;
    logic             stale;
    logic             too_short;
    logic             full;
    logic [LEN_W-1:0] payload;
    logic [SEQ_W:0]   entry_end;
    logic             keep_hit;
    logic [LEN_W-1:0] hdr_ext;

    assign hdr_ext   = {{(LEN_W-HDR_W){1'b0}}, hdr_reg};
    assign payload   = (rd_data_reg.length >= hdr_ext) ? (rd_data_reg.length - hdr_ext)
                                                       : '0;
    assign entry_end = {1'b0, rd_data_reg.start} + {{(SEQ_W+1-LEN_W){1'b0}}, payload};
    assign keep_hit  = entry_end > {1'b0, req_reg.ack_number};
    assign walk_done = (rd_idx_reg >= count_reg) && !pend_reg;
    assign issue     = cmd.walk_step && (rd_idx_reg < count_reg);
    assign stale     = req_reg.ack_number < base_reg;
    assign too_short = req_reg.pkt_len < hdr_ext;
    assign full      = count_reg >= DEPTH_CNT;

    assign sts.kind      = req_reg.req_type;
    assign sts.stale     = stale;
    assign sts.walk_done = walk_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        base_next      = base_reg;
        next_next      = next_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        keep_next      = keep_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = '{start: next_reg, length: req_reg.pkt_len};

        if (cmd.load)
        begin
            req_next = in_data;
        end

        if (cmd.decode)
        begin
            case (req_reg.req_type)
                REQ_SEND:
                begin
                    res_next = '0;
                    if (too_short)
                    begin
                        res_next.status = STS_TOO_SHORT;
                    end
                    else if (full)
                    begin
                        res_next.status = STS_FULL;
                    end
                    else
                    begin
                        res_next.status       = STS_SENT;
                        res_next.seq_out      = next_reg;
                        res_next.timer_action = (base_reg == next_reg) ? TMR_START : TMR_NONE;
                        mem_we                = 1'b1;
                        count_next            = count_reg + 1'b1;
                        next_next             = next_reg
                            + {{(SEQ_W-LEN_W){1'b0}}, req_reg.pkt_len - hdr_ext};
                    end
                end
                REQ_ACK:
                begin
                    res_next = '0;
                    if (stale)
                    begin
                        res_next.status       = STS_ACK_STALE;
                        res_next.timer_action = TMR_NONE;
                    end
                    else
                    begin
                        base_next   = req_reg.ack_number;
                        rd_idx_next = '0;
                        keep_next   = '0;
                        pend_next   = 1'b0;
                    end
                end
                REQ_TIMEOUT:
                begin
                    rd_idx_next           = '0;
                    pend_next             = 1'b0;
                    found_next            = 1'b0;
                    res_next              = '0;
                    res_next.status       = STS_NO_RESEND;
                    res_next.timer_action = TMR_START;
                end
                default:
                begin
                    res_next = res_reg;
                end
            endcase
        end

        if (cmd.walk_step)
        begin
            pend_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            if (pend_reg)
            begin
                // compact survivors toward the front, keeping their order
                if ((req_reg.req_type == REQ_ACK) && keep_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = keep_reg[IDX_W-1:0];
                    mem_wdata = rd_data_reg;
                    keep_next = keep_reg + 1'b1;
                end
                if ((req_reg.req_type == REQ_TIMEOUT) && !found_reg
                    && (rd_data_reg.start == base_reg))
                begin
                    found_next            = 1'b1;
                    res_next              = '0;
                    res_next.status       = STS_RETX;
                    res_next.seq_out      = rd_data_reg.start;
                    res_next.len_out      = rd_data_reg.length;
                    res_next.timer_action = TMR_START;
                end
            end
            if (walk_done && (req_reg.req_type == REQ_ACK))
            begin
                count_next            = keep_reg;
                res_next              = '0;
                res_next.status       = STS_ACK_TAKEN;
                res_next.timer_action = (base_reg != next_reg) ? TMR_START : TMR_STOP;
            end
        end

        if (cmd.emit)
        begin
            out_data_next             = res_reg;
            out_data_next.outstanding = OUT_CNT_W'(count_reg);
            out_valid_next            = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= HDR_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            keep_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hdr_reg <= cfg_wr_data;
            end
            base_reg      <= base_next;
            next_reg      <= next_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            keep_reg      <= keep_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire
